@@ sv/median_3x3_line_filter_defines.svh @@
// Assertion macros for the 3x3 median line filter.
`ifndef MEDIAN_3X3_LINE_FILTER_DEFINES_SVH
`define MEDIAN_3X3_LINE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define M3LF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define M3LF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/m3lf_pkg.sv @@
// Shared types and constants for the 3x3 median line filter.
package m3lf_pkg;

  localparam int PIX_W = 8;
  localparam int LW_W  = 13;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 13'd720;

  typedef logic [PIX_W-1:0] pixel_t;

  // [0] top, [1] mid, [2] bottom
  typedef pixel_t [2:0] column_t;

  // Row-major 3x3 window, [0] upper left
  typedef pixel_t [8:0] window_t;

  typedef struct packed {
    pixel_t pixel;
    logic   line_done;
    logic   run_last;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ sv/m3lf_median9.sv @@
// Nine-input median by the 19-step compare-swap network.
module m3lf_median9 (
  input  m3lf_pkg::window_t win,
  output m3lf_pkg::pixel_t  median
);

  // Returns {min, max}.
  function automatic logic [2*m3lf_pkg::PIX_W-1:0] order2(input m3lf_pkg::pixel_t a,
                                                         input m3lf_pkg::pixel_t b);
    order2 = (a > b) ? {b, a} : {a, b};
  endfunction

  always_comb begin : sort_net
    m3lf_pkg::window_t v;
    v = win;
    {v[1], v[2]} = order2(v[1], v[2]);
    {v[4], v[5]} = order2(v[4], v[5]);
    {v[7], v[8]} = order2(v[7], v[8]);
    {v[0], v[1]} = order2(v[0], v[1]);
    {v[3], v[4]} = order2(v[3], v[4]);
    {v[6], v[7]} = order2(v[6], v[7]);
    {v[1], v[2]} = order2(v[1], v[2]);
    {v[4], v[5]} = order2(v[4], v[5]);
    {v[7], v[8]} = order2(v[7], v[8]);
    {v[0], v[3]} = order2(v[0], v[3]);
    {v[5], v[8]} = order2(v[5], v[8]);
    {v[4], v[7]} = order2(v[4], v[7]);
    {v[3], v[6]} = order2(v[3], v[6]);
    {v[1], v[4]} = order2(v[1], v[4]);
    {v[2], v[5]} = order2(v[2], v[5]);
    {v[4], v[7]} = order2(v[4], v[7]);
    {v[4], v[2]} = order2(v[4], v[2]);
    {v[6], v[4]} = order2(v[6], v[4]);
    {v[4], v[2]} = order2(v[4], v[2]);
    median = v[4];
  end

endmodule

@@ sv/m3lf_out_fifo.sv @@
// Two-entry result queue; takes up to two results per cycle, gives one.
module m3lf_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  m3lf_pkg::push_t   push,
  input  logic              out_ready,
  output m3lf_pkg::result_t head,
  output logic              out_valid,
  output logic [1:0]        room
);

  logic [1:0]        cnt_r, cnt_nxt, cnt_pop;
  m3lf_pkg::result_t slot0_r, slot0_nxt;
  m3lf_pkg::result_t slot1_r, slot1_nxt;
  logic              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = slot0_r;
  assign pop       = out_valid && out_ready;
  assign cnt_pop   = cnt_r - {1'b0, pop};
  assign room      = 2'd2 - cnt_pop;

  always_comb begin
    slot0_nxt = pop ? slot1_r : slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_pop;
    if (push.en) begin
      cnt_nxt = cnt_pop + push.count;
      case (cnt_pop)
        2'd0: begin
          slot0_nxt = push.first;
          slot1_nxt = push.second;
        end
        2'd1: begin
          slot1_nxt = push.first;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

@@ sv/median_3x3_line_filter.sv @@
// Top level of the 3x3 median line filter.
//
// Input channel (in_valid/in_ready): one image column per item, the pixels of
// the row above, the centre row and the row below. Output channel
// (out_valid/out_ready): one filtered pixel per item, with out_line_done on the
// last pixel of a line and out_run_last on the last result of an input item.
// Config channel (cfg_valid/cfg_ready): pixels per line, always ready; write
// only while the block is idle. Widths of 0 or 1 pass every column through.
// Column 0 gives its centre pixel, column 1 gives nothing, every later column
// gives the median of the window centred on the column before; the last column
// also gives its own centre pixel, so a line of W columns yields W pixels.
// A result passes the column register, then the median network into the result
// queue, before it can be taken. Throughput: 1 item per cycle while the receiver
// takes results; for widths of 3 or more the line-end item places two results
// into the two-entry result queue, which the zero-result second column of the
// next line drains again. A stalled receiver backs up the queue and then the
// column register, and in_ready drops. Reset empties both and restarts at
// column 0 with a line width of 720.
`include "median_3x3_line_filter_defines.svh"

module median_3x3_line_filter #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [m3lf_pkg::LW_W-1:0]   cfg_line_width,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [m3lf_pkg::PIX_W-1:0]  in_top_pixel,
  input  logic [m3lf_pkg::PIX_W-1:0]  in_mid_pixel,
  input  logic [m3lf_pkg::PIX_W-1:0]  in_bottom_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [m3lf_pkg::PIX_W-1:0]  out_pixel,
  output logic                        out_line_done,
  output logic                        out_run_last
);

  localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int EW = (CW + 1 > m3lf_pkg::LW_W) ? CW + 1 : m3lf_pkg::LW_W;

  logic [m3lf_pkg::LW_W-1:0] lw_r;
  logic [CW-1:0]             colidx_r, colidx_nxt;
  logic [EW-1:0]             col_inc, lw_ext, eff_w;
  logic                      last_nxt;
  logic                      in_acc;

  m3lf_pkg::column_t cur_r, prev_r, prev2_r;
  logic              a_valid_r, a_valid_nxt;
  logic              a_zero_r, a_one_r, a_last_r;
  logic              a_move;

  m3lf_pkg::window_t win;
  m3lf_pkg::pixel_t  median;
  m3lf_pkg::push_t   push;
  m3lf_pkg::result_t res_first, res_second;
  m3lf_pkg::result_t head;
  logic [1:0]        room;
  logic [1:0]        res_n;

  // Config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= m3lf_pkg::LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lw_r <= cfg_line_width;
    end
  end

  // Column position and line end
  always_comb begin
    col_inc = EW'(colidx_r) + EW'(1);
    lw_ext  = EW'(lw_r);
    if (lw_ext == '0) begin
      eff_w = EW'(1);
    end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
      eff_w = EW'(MAX_LINE_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    last_nxt   = (col_inc >= eff_w);
    colidx_nxt = last_nxt ? '0 : col_inc[CW-1:0];
  end

  assign in_ready    = !a_valid_r || a_move;
  assign in_acc      = in_valid && in_ready;
  assign a_valid_nxt = in_acc ? 1'b1 : (a_move ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colidx_r  <= '0;
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (in_acc) begin
        colidx_r <= colidx_nxt;
      end
    end
  end

  // Column shift line; doubles as the input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev2_r  <= prev_r;
      prev_r   <= cur_r;
      cur_r    <= {in_bottom_pixel, in_mid_pixel, in_top_pixel};
      a_zero_r <= (colidx_r == '0);
      a_one_r  <= (colidx_r == CW'(1));
      a_last_r <= last_nxt;
    end
  end

  assign win = {cur_r[2], prev_r[2], prev2_r[2],
                cur_r[1], prev_r[1], prev2_r[1],
                cur_r[0], prev_r[0], prev2_r[0]};

  m3lf_median9 u_median (
    .win    (win),
    .median (median)
  );

  // Results of the held column
  always_comb begin
    res_second = '{pixel: cur_r[1], line_done: 1'b1, run_last: 1'b1};
    if (a_zero_r) begin
      res_n     = 2'd1;
      res_first = '{pixel: cur_r[1], line_done: a_last_r, run_last: 1'b1};
    end else if (a_one_r) begin
      res_n     = a_last_r ? 2'd1 : 2'd0;
      res_first = '{pixel: cur_r[1], line_done: 1'b1, run_last: 1'b1};
    end else begin
      res_n     = a_last_r ? 2'd2 : 2'd1;
      res_first = '{pixel: median, line_done: 1'b0, run_last: !a_last_r};
    end
  end

  assign a_move = a_valid_r && (res_n <= room);
  assign push   = '{en: a_move, count: res_n, first: res_first, second: res_second};

  m3lf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_ready),
    .head      (head),
    .out_valid (out_valid),
    .room      (room)
  );

  assign out_pixel     = head.pixel;
  assign out_line_done = head.line_done;
  assign out_run_last  = head.run_last;

  `M3LF_ASSERT_SAME(a_done_last, out_valid && out_line_done, out_run_last, "line end not last")
  `M3LF_ASSERT_SAME(a_no_stall, a_valid_r && out_ready && res_n < 2'd2, a_move, "column stalled")
  `M3LF_ASSERT_NEXT(a_restart, in_acc && last_nxt, colidx_r == '0, "counter not restarted")

endmodule
